[rtl/sorted_keyed_table_upsert_remove_unit_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the sorted keyed table
// ----------------------------------------------------------------------------
`ifndef SORTED_KEYED_TABLE_UPSERT_REMOVE_UNIT_ASSERT_SVH
`define SORTED_KEYED_TABLE_UPSERT_REMOVE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SKTUR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SKTUR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sktur_pkg.sv]
// ----------------------------------------------------------------------------
// sktur_pkg
// codes, entry layout and controller/datapath bundles of the sorted table
// ----------------------------------------------------------------------------
`default_nettype none

package sktur_pkg;

  localparam logic [1:0] CMD_UPSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;

  localparam logic [1:0] RD_IDX    = 2'd0;
  localparam logic [1:0] RD_MV_DN  = 2'd1;
  localparam logic [1:0] RD_MV_UP  = 2'd2;
  localparam logic [1:0] RD_POS    = 2'd3;

  localparam logic WR_NEW  = 1'b0;
  localparam logic WR_MOVE = 1'b1;

  localparam logic [1:0] SLOT_IDX  = 2'd0;
  localparam logic [1:0] SLOT_POS  = 2'd1;
  localparam logic [1:0] SLOT_ZERO = 2'd2;

  typedef struct packed {
    logic [15:0] block_index;
    logic [15:0] region;
    logic [31:0] paint_id;
    logic [31:0] color_a;
    logic [31:0] color_b;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       mv_load_cnt;
    logic       mv_load_idx;
    logic       mv_inc;
    logic       mv_dec;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_set;
    logic [2:0] res_status;
    logic [1:0] res_slot_sel;
    logic       res_data;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       idx_at_end;
    logic       full;
    logic       key_lt;
    logic       key_eq;
    logic       pos_valid;
    logic       mv_at_idx;
    logic       mv_at_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/sktur_if.sv]
// ----------------------------------------------------------------------------
// sktur channel interfaces
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface sktur_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] block_index;
  logic [15:0] region;
  logic [31:0] paint_id;
  logic [31:0] color_a;
  logic [31:0] color_b;
  logic [5:0]  position;

  modport source (
    output valid, cmd, block_index, region, paint_id, color_a, color_b, position,
    input  ready
  );
  modport sink (
    input  valid, cmd, block_index, region, paint_id, color_a, color_b, position,
    output ready
  );
endinterface

interface sktur_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  entry_count;
  logic [5:0]  slot;
  logic [15:0] out_block_index;
  logic [15:0] out_region;
  logic [31:0] out_paint_id;
  logic [31:0] out_color_a;
  logic [31:0] out_color_b;

  modport source (
    output valid, status, entry_count, slot, out_block_index, out_region,
           out_paint_id, out_color_a, out_color_b,
    input  ready
  );
  modport sink (
    input  valid, status, entry_count, slot, out_block_index, out_region,
           out_paint_id, out_color_a, out_color_b,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sktur_dp.sv]
// ----------------------------------------------------------------------------
// sktur_dp
// entry memory, scan and move pointers, entry count and result registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_keyed_table_upsert_remove_unit_assert.svh"

module sktur_dp #(
  parameter int TABLE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sktur_pkg::ctrl_cmd_t cmd_i,
  output sktur_pkg::dp_stat_t       stat_o,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [15:0]          in_block_index,
  input  wire logic [15:0]          in_region,
  input  wire logic [31:0]          in_paint_id,
  input  wire logic [31:0]          in_color_a,
  input  wire logic [31:0]          in_color_b,
  input  wire logic [5:0]           in_position,
  output logic [2:0]                out_status,
  output logic [6:0]                out_entry_count,
  output logic [5:0]                out_slot,
  output sktur_pkg::entry_t         out_entry
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  sktur_pkg::entry_t mem [TABLE_DEPTH];
  sktur_pkg::entry_t rd_data_r;
  sktur_pkg::entry_t new_r;
  sktur_pkg::entry_t res_data_r;
  sktur_pkg::entry_t out_data_r;
  sktur_pkg::entry_t wr_data;

  logic [1:0]    cmd_r;
  logic [5:0]    pos_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] mv_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] mv_plus;
  logic [CW-1:0] mv_minus;
  logic [CW+5:0] pos_ext;
  logic [CW+5:0] idx_ext;
  logic [CW+6:0] cnt_ext;
  logic [CW+5:0] cnt_cmp;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   rd_key;
  logic [31:0]   new_key;

  logic [2:0] res_status_r;
  logic [5:0] res_slot_r;
  logic [5:0] slot_sel;
  logic [2:0] out_status_r;
  logic [6:0] out_count_r;
  logic [5:0] out_slot_r;

  assign mv_plus  = mv_r + 1'b1;
  assign mv_minus = mv_r - 1'b1;
  assign pos_ext  = {{CW{1'b0}}, pos_r};
  assign idx_ext  = {6'b0, idx_r};
  assign cnt_ext  = {7'b0, count_r};
  assign cnt_cmp  = {6'b0, count_r};
  assign rd_key   = {rd_data_r.block_index, rd_data_r.region};
  assign new_key  = {new_r.block_index, new_r.region};

  always_comb begin
    stat_o.cmd        = cmd_r;
    stat_o.idx_at_end = (idx_r == count_r);
    stat_o.full       = (count_r == DEPTH_C);
    stat_o.key_lt     = (rd_key < new_key);
    stat_o.key_eq     = (rd_key == new_key);
    stat_o.pos_valid  = (pos_ext < cnt_cmp);
    stat_o.mv_at_idx  = (mv_r == idx_r);
    stat_o.mv_at_last = (mv_plus == count_r);
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      sktur_pkg::RD_IDX:   rd_addr = idx_r[AW-1:0];
      sktur_pkg::RD_MV_DN: rd_addr = mv_minus[AW-1:0];
      sktur_pkg::RD_MV_UP: rd_addr = mv_plus[AW-1:0];
      sktur_pkg::RD_POS:   rd_addr = pos_ext[AW-1:0];
      default:             rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    if (cmd_i.wr_sel == sktur_pkg::WR_MOVE) begin
      wr_addr = mv_r[AW-1:0];
      wr_data = rd_data_r;
    end else begin
      wr_addr = idx_r[AW-1:0];
      wr_data = new_r;
    end
  end

  always_comb begin
    unique case (cmd_i.res_slot_sel)
      sktur_pkg::SLOT_IDX: slot_sel = idx_ext[5:0];
      sktur_pkg::SLOT_POS: slot_sel = pos_r;
      default:             slot_sel = 6'd0;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd_i.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r             <= in_cmd;
      pos_r             <= in_position;
      new_r.block_index <= in_block_index;
      new_r.region      <= in_region;
      new_r.paint_id    <= in_paint_id;
      new_r.color_a     <= in_color_a;
      new_r.color_b     <= in_color_b;
    end
    if (cmd_i.load) begin
      idx_r <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd_i.mv_load_cnt) begin
      mv_r <= count_r;
    end else if (cmd_i.mv_load_idx) begin
      mv_r <= idx_r;
    end else if (cmd_i.mv_inc) begin
      mv_r <= mv_plus;
    end else if (cmd_i.mv_dec) begin
      mv_r <= mv_minus;
    end
    if (cmd_i.res_set) begin
      res_status_r <= cmd_i.res_status;
      res_slot_r   <= slot_sel;
      res_data_r   <= cmd_i.res_data ? rd_data_r : '0;
    end
    if (cmd_i.out_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= cnt_ext[6:0];
      out_slot_r   <= res_slot_r;
      out_data_r   <= res_data_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_slot        = out_slot_r;
  assign out_entry       = out_data_r;

  `SKTUR_ASSERT_NOW(a_ins_room, cmd_i.cnt_inc, count_r != DEPTH_C, "insert into full table")
  `SKTUR_ASSERT_NEXT(a_ins_count, cmd_i.cnt_inc, count_r == $past(count_r) + 1'b1, "count not bumped")
  `SKTUR_ASSERT_NOW(a_rm_src, cmd_i.rd_en && (cmd_i.rd_sel == sktur_pkg::RD_MV_UP), mv_plus < count_r, "move source past end")

endmodule

`default_nettype wire

[rtl/sktur_ctrl.sv]
// ----------------------------------------------------------------------------
// sktur_ctrl
// command sequencer: key scan, shift up, shift down, read and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_keyed_table_upsert_remove_unit_assert.svh"

module sktur_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire sktur_pkg::dp_stat_t stat_i,
  output sktur_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_INS    = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_RM     = 4'd6;
  localparam logic [3:0] S_RM_WR  = 4'd7;
  localparam logic [3:0] S_RDW    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       is_upsert;

  assign is_upsert = (stat_i.cmd == sktur_pkg::CMD_UPSERT);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd_o         = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.cmd) inside
          sktur_pkg::CMD_UPSERT, sktur_pkg::CMD_REMOVE: begin
            state_nxt = S_SCAN;
          end
          sktur_pkg::CMD_READ: begin
            if (stat_i.pos_valid) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = sktur_pkg::RD_POS;
              state_nxt    = S_RDW;
            end else begin
              cmd_o.res_set      = 1'b1;
              cmd_o.res_status   = sktur_pkg::ST_NOTFOUND;
              cmd_o.res_slot_sel = sktur_pkg::SLOT_POS;
              state_nxt          = S_DONE;
            end
          end
          default: begin
            cmd_o.res_set      = 1'b1;
            cmd_o.res_status   = sktur_pkg::ST_NOTFOUND;
            cmd_o.res_slot_sel = sktur_pkg::SLOT_ZERO;
            state_nxt          = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.idx_at_end) begin
          if (is_upsert && !stat_i.full) begin
            cmd_o.mv_load_cnt = 1'b1;
            state_nxt         = S_INS;
          end else begin
            cmd_o.res_set      = 1'b1;
            cmd_o.res_status   = is_upsert ? sktur_pkg::ST_FULL : sktur_pkg::ST_NOTFOUND;
            cmd_o.res_slot_sel = sktur_pkg::SLOT_IDX;
            state_nxt          = S_DONE;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sktur_pkg::RD_IDX;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.key_lt) begin
          cmd_o.idx_inc = 1'b1;
          state_nxt     = S_SCAN;
        end else if (stat_i.key_eq) begin
          if (is_upsert) begin
            cmd_o.wr_en        = 1'b1;
            cmd_o.wr_sel       = sktur_pkg::WR_NEW;
            cmd_o.res_set      = 1'b1;
            cmd_o.res_status   = sktur_pkg::ST_REPLACED;
            cmd_o.res_slot_sel = sktur_pkg::SLOT_IDX;
            state_nxt          = S_DONE;
          end else begin
            cmd_o.mv_load_idx = 1'b1;
            state_nxt         = S_RM;
          end
        end else if (is_upsert && !stat_i.full) begin
          cmd_o.mv_load_cnt = 1'b1;
          state_nxt         = S_INS;
        end else begin
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = is_upsert ? sktur_pkg::ST_FULL : sktur_pkg::ST_NOTFOUND;
          cmd_o.res_slot_sel = sktur_pkg::SLOT_IDX;
          state_nxt          = S_DONE;
        end
      end
      S_INS: begin
        if (stat_i.mv_at_idx) begin
          cmd_o.wr_en        = 1'b1;
          cmd_o.wr_sel       = sktur_pkg::WR_NEW;
          cmd_o.cnt_inc      = 1'b1;
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = sktur_pkg::ST_INSERTED;
          cmd_o.res_slot_sel = sktur_pkg::SLOT_IDX;
          state_nxt          = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sktur_pkg::RD_MV_DN;
          state_nxt    = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = sktur_pkg::WR_MOVE;
        cmd_o.mv_dec = 1'b1;
        state_nxt    = S_INS;
      end
      S_RM: begin
        if (stat_i.mv_at_last) begin
          cmd_o.cnt_dec      = 1'b1;
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = sktur_pkg::ST_REMOVED;
          cmd_o.res_slot_sel = sktur_pkg::SLOT_IDX;
          state_nxt          = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sktur_pkg::RD_MV_UP;
          state_nxt    = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = sktur_pkg::WR_MOVE;
        cmd_o.mv_inc = 1'b1;
        state_nxt    = S_RM;
      end
      S_RDW: begin
        cmd_o.res_set      = 1'b1;
        cmd_o.res_status   = sktur_pkg::ST_READ;
        cmd_o.res_slot_sel = sktur_pkg::SLOT_POS;
        cmd_o.res_data     = 1'b1;
        state_nxt          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SKTUR_ASSERT_NEXT(a_accept_disp, in_valid && in_ready, state_r == S_DISP, "accept did not dispatch")
  `SKTUR_ASSERT_NOW(a_load_free, cmd_o.out_load, !out_valid_r || out_ready, "result overwritten")
  `SKTUR_ASSERT_NEXT(a_load_shown, cmd_o.out_load, out_valid_r && (state_r == S_IDLE), "result not shown")

endmodule

`default_nettype wire

[rtl/sorted_keyed_table_upsert_remove_unit.sv]
// ----------------------------------------------------------------------------
// sorted_keyed_table_upsert_remove_unit
// Table of up to TABLE_DEPTH entries kept in ascending order of the key
// (block_index, region), each with a paint id and two colour words. Upsert
// replaces a matching entry or inserts at the sorted place; remove deletes a
// matching entry and closes the gap; read returns the entry at a position.
// One command is handled at a time. The entry store is a memory with one
// write and one registered read a cycle, so the search reads and compares
// each entry passed, and an insert or remove moves each shifted entry with
// a read and a write. The result sits in an output register, so the next
// command is accepted while it waits. No clearing pass follows reset; only
// entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_keyed_table_upsert_remove_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input wire logic    clk,
  input wire logic    rst_n,
  sktur_in_if.sink    in_ch,
  sktur_out_if.source out_ch
);

  sktur_pkg::ctrl_cmd_t ctrl_cmd;
  sktur_pkg::dp_stat_t  dp_stat;
  sktur_pkg::entry_t    out_entry;

  logic       in_ready;
  logic       out_valid;
  logic [2:0] out_status;
  logic [6:0] out_entry_count;
  logic [5:0] out_slot;

  sktur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat_i    (dp_stat),
    .cmd_o     (ctrl_cmd)
  );

  sktur_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .in_cmd          (in_ch.cmd),
    .in_block_index  (in_ch.block_index),
    .in_region       (in_ch.region),
    .in_paint_id     (in_ch.paint_id),
    .in_color_a      (in_ch.color_a),
    .in_color_b      (in_ch.color_b),
    .in_position     (in_ch.position),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_slot        (out_slot),
    .out_entry       (out_entry)
  );

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.status          = out_status;
  assign out_ch.entry_count     = out_entry_count;
  assign out_ch.slot            = out_slot;
  assign out_ch.out_block_index = out_entry.block_index;
  assign out_ch.out_region      = out_entry.region;
  assign out_ch.out_paint_id    = out_entry.paint_id;
  assign out_ch.out_color_a     = out_entry.color_a;
  assign out_ch.out_color_b     = out_entry.color_b;

endmodule

`default_nettype wire

[bench/sorted_table_checker.sv]
// ----------------------------------------------------------------------------
// sorted_table_checker
// Watches the command and result channels of the sorted keyed table. Every
// accepted command word is applied to a local copy of the sorted table to
// predict its result word; every accepted result word is compared field by
// field with the oldest prediction. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  sktur_in_if       in_ch,
  sktur_out_if      out_ch,
  output int        fail_count,
  output int        outstanding
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [2:0]        status;
    logic [6:0]        entry_count;
    logic [5:0]        slot;
    sktur_pkg::entry_t data;
  } result_t;

  sktur_pkg::entry_t rows [DEPTH];
  int                row_count;
  result_t           expected_results [$];
  int                mismatches = 0;

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  function automatic result_t apply_command(logic [1:0] cmd, sktur_pkg::entry_t item,
                                            logic [5:0] position);
    result_t     r;
    int          i;
    logic [31:0] key;
    r = '0;
    key = {item.block_index, item.region};
    i = 0;
    if (cmd == sktur_pkg::CMD_UPSERT || cmd == sktur_pkg::CMD_REMOVE) begin
      while (i < row_count && {rows[i].block_index, rows[i].region} < key) i++;
    end
    case (cmd)
      sktur_pkg::CMD_UPSERT: begin
        if (i < row_count && {rows[i].block_index, rows[i].region} == key) begin
          rows[i] = item;
          r.status = sktur_pkg::ST_REPLACED;
        end else if (row_count >= DEPTH) begin
          r.status = sktur_pkg::ST_FULL;
        end else begin
          for (int j = row_count; j > i; j--) rows[j] = rows[j - 1];
          rows[i] = item;
          row_count++;
          r.status = sktur_pkg::ST_INSERTED;
        end
        r.slot = i[5:0];
      end
      sktur_pkg::CMD_REMOVE: begin
        if (i < row_count && {rows[i].block_index, rows[i].region} == key) begin
          for (int j = i; j < row_count - 1; j++) rows[j] = rows[j + 1];
          row_count--;
          r.status = sktur_pkg::ST_REMOVED;
        end else begin
          r.status = sktur_pkg::ST_NOTFOUND;
        end
        r.slot = i[5:0];
      end
      sktur_pkg::CMD_READ: begin
        r.slot = position;
        if (int'(position) < row_count) begin
          r.status = sktur_pkg::ST_READ;
          r.data = rows[position];
        end else begin
          r.status = sktur_pkg::ST_NOTFOUND;
        end
      end
      default: r.status = sktur_pkg::ST_NOTFOUND;
    endcase
    r.entry_count = row_count[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t           seen;
    result_t           want;
    sktur_pkg::entry_t item;
    if (!rst_n) begin
      row_count = 0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.status = out_ch.status;
        seen.entry_count = out_ch.entry_count;
        seen.slot = out_ch.slot;
        seen.data = {out_ch.out_block_index, out_ch.out_region, out_ch.out_paint_id,
                     out_ch.out_color_a, out_ch.out_color_b};
        if (expected_results.size() == 0) begin
          report("result word with no command pending");
        end else begin
          want = expected_results.pop_front();
          check_field("status", seen.status, want.status);
          check_field("entry_count", seen.entry_count, want.entry_count);
          check_field("slot", seen.slot, want.slot);
          check_field("out_block_index", seen.data.block_index, want.data.block_index);
          check_field("out_region", seen.data.region, want.data.region);
          check_field("out_paint_id", seen.data.paint_id, want.data.paint_id);
          check_field("out_color_a", seen.data.color_a, want.data.color_a);
          check_field("out_color_b", seen.data.color_b, want.data.color_b);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item = {in_ch.block_index, in_ch.region, in_ch.paint_id,
                in_ch.color_a, in_ch.color_b};
        expected_results.insert(expected_results.size(),
                                apply_command(in_ch.cmd, item, in_ch.position));
      end
    end
    fail_count <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

`default_nettype wire

[bench/sorted_keyed_table_upsert_remove_unit_test.sv]
// ----------------------------------------------------------------------------
// sorted_keyed_table_upsert_remove_unit_test
// Drives the sorted keyed table with a directed run over empty, edge and miss
// cases, then with epochs that grow the table from a key pool towards full,
// churn it with mixed commands and drain it again. Both channels idle
// at random; the result side holds off once long enough to stall commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_keyed_table_upsert_remove_unit_test;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int POOL = 96;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_WAIT = 300;

  logic clk = 1'b0;
  logic rst_n;
  int   fails;
  int   pending;
  int   quiet = 0;
  int   in_calm = 0;
  int   out_calm = 0;
  logic [31:0] key_pool [POOL];

  sktur_in_if  in_ch ();
  sktur_out_if out_ch ();

  sorted_keyed_table_upsert_remove_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_table_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fails),
    .outstanding (pending)
  );

  always #2 clk = ~clk;

  function automatic int draw_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic offer(logic [1:0] cmd, logic [31:0] key, logic [31:0] pid,
                       logic [31:0] ca, logic [31:0] cb, logic [5:0] pos);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.block_index <= key[31:16];
    in_ch.region <= key[15:0];
    in_ch.paint_id <= pid;
    in_ch.color_a <= ca;
    in_ch.color_b <= cb;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic upsert_key(logic [31:0] key);
    offer(sktur_pkg::CMD_UPSERT, key, $urandom(), $urandom(), $urandom(), 6'($urandom()));
  endtask

  task automatic remove_key(logic [31:0] key);
    offer(sktur_pkg::CMD_REMOVE, key, $urandom(), $urandom(), $urandom(), 6'($urandom()));
  endtask

  task automatic read_at(logic [5:0] pos);
    offer(sktur_pkg::CMD_READ, $urandom(), $urandom(), $urandom(), $urandom(), pos);
  endtask

  task automatic noise();
    offer(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(), 6'($urandom()));
  endtask

  // stall watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side, with one long hold-off
  initial begin
    int gap;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    int          roll;
    int          nxt;
    int          j;
    bit          narrow;
    logic [15:0] bases [4];
    logic [31:0] k;
    logic [31:0] t;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = sktur_pkg::CMD_UPSERT;
    in_ch.block_index = '0;
    in_ch.region = '0;
    in_ch.paint_id = '0;
    in_ch.color_a = '0;
    in_ch.color_b = '0;
    in_ch.position = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, edges of the key space, replace, reads past the count
    read_at(6'd0);
    remove_key(32'h0001_0001);
    offer(sktur_pkg::CMD_UPSERT, 32'h0000_0000, '0, '0, '0, 6'd0);
    offer(sktur_pkg::CMD_UPSERT, 32'hFFFF_FFFF, '1, '1, '1, 6'd63);
    offer(sktur_pkg::CMD_UPSERT, 32'h8000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
          32'h0F0F_F0F0, 6'd21);
    upsert_key(32'h8000_0000);
    upsert_key(32'h7FFF_FFFF);
    offer(sktur_pkg::CMD_UPSERT, 32'h0000_0000, '1, '1, '1, 6'd42);
    for (int p = 0; p < 6; p++) read_at(6'(p));
    read_at(6'd63);
    remove_key(32'h8000_0002);
    remove_key(32'hFFFF_FFFF);
    remove_key(32'h0000_0000);
    remove_key(32'h8000_0000);
    offer(CMD_UNUSED, '1, '1, '1, '1, '1);
    offer(CMD_UNUSED, '0, '0, '0, '0, '0);
    remove_key(32'h7FFF_FFFF);
    remove_key(32'h8000_0001);

    for (int ep = 0; ep < 4; ep++) begin
      narrow = 1'($urandom());
      foreach (bases[b]) bases[b] = 16'($urandom());
      for (int i = 0; i < POOL; i++) begin
        if (narrow && $urandom_range(0, 1) == 1)
          key_pool[i] = {bases[$urandom_range(0, 3)], 16'($urandom_range(0, 31))};
        else
          key_pool[i] = $urandom();
      end

      // grow mostly with fresh pool keys, towards a full table that refuses inserts
      nxt = 0;
      repeat (120) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          if (nxt < POOL && $urandom_range(0, 6) != 0) begin
            k = key_pool[nxt];
            nxt++;
          end else begin
            k = key_pool[$urandom_range(0, POOL - 1)];
          end
          upsert_key(k);
        end else if (roll < 90) begin
          read_at(6'($urandom()));
        end else if (roll < 95) begin
          remove_key(key_pool[$urandom_range(0, POOL - 1)]);
        end else begin
          noise();
        end
      end

      // mixed traffic on the same keys
      repeat (110) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) upsert_key(key_pool[$urandom_range(0, POOL - 1)]);
        else if (roll < 70) remove_key(key_pool[$urandom_range(0, POOL - 1)]);
        else if (roll < 95) read_at(6'($urandom()));
        else noise();
      end

      // drain every pool key in shuffled order
      for (int i = POOL - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = key_pool[i];
        key_pool[i] = key_pool[j];
        key_pool[j] = t;
      end
      for (int i = 0; i < POOL; i++) begin
        remove_key(key_pool[i]);
        if ($urandom_range(0, 4) == 0) read_at(6'($urandom()));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/sktur_pkg.sv
rtl/sktur_if.sv
rtl/sktur_dp.sv
rtl/sktur_ctrl.sv
rtl/sorted_keyed_table_upsert_remove_unit.sv
bench/sorted_table_checker.sv
bench/sorted_keyed_table_upsert_remove_unit_test.sv
